### hw/rtl/cwe_pkg.sv
// Package for the compacted width-array encoder: widths, token kinds and
// the structs passed between the encoder core, the token queue and the top level.
// No dependencies.
package cwe_pkg;

  // Glyph ids use the low ID_BITS bits; widths carry FRAC_BITS fraction bits.
  localparam int unsigned ID_BITS       = 16;
  localparam int unsigned FRAC_BITS     = 8;

  localparam int unsigned GLYPH_ID_W    = 16;
  localparam int unsigned GLYPH_WIDTH_W = 24;
  localparam int unsigned TOKEN_KIND_W  = 3;
  localparam int unsigned TOKEN_VALUE_W = 16;

  // Worst case per request: a flushed range followed by a one-glyph list.
  localparam int unsigned MAX_TOKENS    = 6;
  localparam int unsigned CNT_W         = $clog2(MAX_TOKENS + 1);
  localparam int unsigned IDX_W         = $clog2(MAX_TOKENS);

  typedef enum logic [TOKEN_KIND_W-1:0] {
    TK_RANGE_FIRST = 3'd0,
    TK_RANGE_LAST  = 3'd1,
    TK_RANGE_WIDTH = 3'd2,
    TK_LIST_START  = 3'd3,
    TK_LIST_WIDTH  = 3'd4,
    TK_LIST_CLOSE  = 3'd5
  } token_kind_e;

  typedef struct packed {
    token_kind_e              kind;
    logic [TOKEN_VALUE_W-1:0] value;
    logic                     done;
  } token_t;

  typedef struct packed {
    logic [GLYPH_ID_W-1:0]    glyph_id;
    logic [GLYPH_WIDTH_W-1:0] glyph_width;
    logic                     final_entry;
  } item_t;

  typedef struct packed {
    token_t [MAX_TOKENS-1:0] tokens;
    logic [CNT_W-1:0]        cnt;
  } batch_t;

  typedef struct packed {
    logic                     pending;
    logic [ID_BITS-1:0]       run_start;
    logic [ID_BITS:0]         run_count;
    logic [GLYPH_WIDTH_W-1:0] run_width;
    logic                     list_open;
  } enc_state_t;

endpackage

### hw/rtl/cwe_item_if.sv
// Input channel of the width-array encoder: one (glyph id, width) request.
// Depends on cwe_pkg for field widths.
interface cwe_item_if;
  logic                              valid;
  logic                              ready;
  logic [cwe_pkg::GLYPH_ID_W-1:0]    glyph_id;
  logic [cwe_pkg::GLYPH_WIDTH_W-1:0] glyph_width;
  logic                              final_entry;

  modport source (output valid, glyph_id, glyph_width, final_entry, input ready);
  modport sink   (input valid, glyph_id, glyph_width, final_entry, output ready);
endinterface

### hw/rtl/cwe_token_if.sv
// Output channel of the width-array encoder: one width-array token.
// Depends on cwe_pkg for field widths.
interface cwe_token_if;
  logic                              valid;
  logic                              ready;
  logic [cwe_pkg::TOKEN_KIND_W-1:0]  token_kind;
  logic [cwe_pkg::TOKEN_VALUE_W-1:0] token_value;
  logic                              array_done;

  modport source (output valid, token_kind, token_value, array_done, input ready);
  modport sink   (input valid, token_kind, token_value, array_done, output ready);
endinterface

### hw/rtl/cwe_encode.sv
// Encoder core: holds the pending run and turns one registered request into
// a batch of up to six tokens plus the next run state. Depends on cwe_pkg.
module cwe_encode (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cwe_pkg::item_t      item_i,
  input  logic                take_i,
  output cwe_pkg::batch_t     batch_o,
  output cwe_pkg::enc_state_t state_o
);

  typedef struct packed {
    cwe_pkg::token_t [2:0] tok;
    logic [1:0]            cnt;
  } part_t;

  localparam int unsigned SUM_W = cwe_pkg::GLYPH_WIDTH_W + 1;
  localparam logic [SUM_W-1:0] HALF = SUM_W'((1 << cwe_pkg::FRAC_BITS) >> 1);
  localparam logic [SUM_W-1:0] UNIT = SUM_W'(1) << cwe_pkg::FRAC_BITS;
  localparam logic [SUM_W-1:0] VAL_MAX = SUM_W'({cwe_pkg::TOKEN_VALUE_W{1'b1}});

  cwe_pkg::enc_state_t st_q, st_d;

  function automatic logic [cwe_pkg::TOKEN_VALUE_W-1:0] round_width(
    input logic [cwe_pkg::GLYPH_WIDTH_W-1:0] w
  );
    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] r;
    sum = {1'b0, w} + HALF;
    r   = sum >> cwe_pkg::FRAC_BITS;
    return (r > VAL_MAX) ? VAL_MAX[cwe_pkg::TOKEN_VALUE_W-1:0]
                         : r[cwe_pkg::TOKEN_VALUE_W-1:0];
  endfunction

  function automatic cwe_pkg::token_t mk(
    input cwe_pkg::token_kind_e k,
    input logic [cwe_pkg::TOKEN_VALUE_W-1:0] v
  );
    cwe_pkg::token_t t;
    t.kind  = k;
    t.value = v;
    t.done  = 1'b0;
    return t;
  endfunction

  // Flush the pending run: one-glyph or open list closes, otherwise a range.
  function automatic part_t flush(input cwe_pkg::enc_state_t s, input logic last);
    part_t p;
    logic [cwe_pkg::ID_BITS:0] last_id;
    p       = '0;
    last_id = {1'b0, s.run_start} + s.run_count - 1'b1;
    if (s.list_open || s.run_count == (cwe_pkg::ID_BITS+1)'(1)) begin
      if (!s.list_open) begin
        p.tok[0] = mk(cwe_pkg::TK_LIST_START, cwe_pkg::TOKEN_VALUE_W'(s.run_start));
        p.tok[1] = mk(cwe_pkg::TK_LIST_WIDTH, round_width(s.run_width));
        p.tok[2] = mk(cwe_pkg::TK_LIST_CLOSE, '0);
        p.cnt    = 2'd3;
      end else begin
        p.tok[0] = mk(cwe_pkg::TK_LIST_WIDTH, round_width(s.run_width));
        p.tok[1] = mk(cwe_pkg::TK_LIST_CLOSE, '0);
        p.cnt    = 2'd2;
      end
    end else begin
      p.tok[0] = mk(cwe_pkg::TK_RANGE_FIRST, cwe_pkg::TOKEN_VALUE_W'(s.run_start));
      p.tok[1] = mk(cwe_pkg::TK_RANGE_LAST,
                    cwe_pkg::TOKEN_VALUE_W'(last_id[cwe_pkg::ID_BITS-1:0]));
      p.tok[2] = mk(cwe_pkg::TK_RANGE_WIDTH, round_width(s.run_width));
      p.cnt    = 2'd3;
    end
    if (last) begin
      p.tok[p.cnt - 2'd1].done = 1'b1;
    end
    return p;
  endfunction

  cwe_pkg::enc_state_t              s;
  part_t                            pa, pb;
  logic [cwe_pkg::ID_BITS-1:0]      id;
  logic [cwe_pkg::GLYPH_WIDTH_W-1:0] w;
  logic [cwe_pkg::ID_BITS+1:0]      next_id;
  logic [cwe_pkg::ID_BITS:0]        last_id;
  logic [SUM_W-1:0]                 diff, mag;
  logic                             differs;

  always_comb begin
    s       = st_q;
    pa      = '0;
    pb      = '0;
    id      = item_i.glyph_id[cwe_pkg::ID_BITS-1:0];
    w       = item_i.glyph_width;
    next_id = {2'b00, st_q.run_start} + {1'b0, st_q.run_count};
    last_id = {1'b0, st_q.run_start} + st_q.run_count - 1'b1;
    diff    = {1'b0, w} - {1'b0, st_q.run_width};
    mag     = diff[SUM_W-1] ? (SUM_W'(0) - diff) : diff;
    differs = (mag >= UNIT);

    if (!st_q.pending) begin
      s.list_open = 1'b0;
      s.pending   = 1'b1;
      s.run_start = id;
      s.run_count = (cwe_pkg::ID_BITS+1)'(1);
      s.run_width = w;
    end else if ({2'b00, id} == next_id) begin
      if (differs) begin
        if (st_q.run_count != (cwe_pkg::ID_BITS+1)'(1) && !st_q.list_open) begin
          pa = flush(st_q, 1'b0);
          s.run_start = id;
          s.run_count = (cwe_pkg::ID_BITS+1)'(1);
          s.run_width = w;
        end else begin
          if (!st_q.list_open) begin
            pa.tok[0] = mk(cwe_pkg::TK_LIST_START,
                           cwe_pkg::TOKEN_VALUE_W'(st_q.run_start));
            pa.tok[1] = mk(cwe_pkg::TK_LIST_WIDTH, round_width(st_q.run_width));
            pa.cnt    = 2'd2;
          end else begin
            pa.tok[0] = mk(cwe_pkg::TK_LIST_WIDTH, round_width(st_q.run_width));
            pa.cnt    = 2'd1;
          end
          s.list_open = 1'b1;
          s.run_width = w;
          s.run_count = st_q.run_count + 1'b1;
        end
      end else if (st_q.list_open) begin
        // Equal width ends the open list; the last listed glyph opens a range.
        pa.tok[0]   = mk(cwe_pkg::TK_LIST_CLOSE, '0);
        pa.cnt      = 2'd1;
        s.list_open = 1'b0;
        s.run_start = last_id[cwe_pkg::ID_BITS-1:0];
        s.run_count = (cwe_pkg::ID_BITS+1)'(2);
      end else begin
        s.run_count = st_q.run_count + 1'b1;
      end
    end else begin
      // Gap or out-of-order id: flush and start over.
      pa = flush(st_q, 1'b0);
      s.list_open = 1'b0;
      s.run_start = id;
      s.run_count = (cwe_pkg::ID_BITS+1)'(1);
      s.run_width = w;
    end

    if (item_i.final_entry) begin
      pb          = flush(s, 1'b1);
      s.pending   = 1'b0;
      s.list_open = 1'b0;
    end

    batch_o = '0;
    for (int i = 0; i < 3; i++) begin
      batch_o.tokens[i] = pa.tok[i];
    end
    for (int j = 0; j < 3; j++) begin
      batch_o.tokens[cwe_pkg::IDX_W'(pa.cnt) + cwe_pkg::IDX_W'(j)] = pb.tok[j];
    end
    batch_o.cnt = cwe_pkg::CNT_W'(pa.cnt) + cwe_pkg::CNT_W'(pb.cnt);

    st_d = take_i ? s : st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '0;
    end else begin
      st_q <= st_d;
    end
  end

  assign state_o = st_q;

endmodule

### hw/rtl/cwe_token_queue.sv
// Token queue: holds one batch of up to six tokens, drains it one token a cycle
// while ready, via a registered output stage. Depends on cwe_pkg, cwe_token_if.
module cwe_token_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  cwe_pkg::batch_t batch_i,
  output logic            free_o,
  cwe_token_if.source     token_o
);

  cwe_pkg::token_t [cwe_pkg::MAX_TOKENS-1:0] slots_q;
  logic [cwe_pkg::CNT_W-1:0]                 cnt_q;
  logic [cwe_pkg::IDX_W-1:0]                 rd_q;
  logic                                      out_valid_q;
  cwe_pkg::token_t                           out_tok_q;
  logic                                      has_tok, pop;

  assign has_tok = cwe_pkg::CNT_W'(rd_q) < cnt_q;
  assign pop     = has_tok && (!out_valid_q || token_o.ready);
  // Free once the last held token moves to the output stage.
  assign free_o  = !has_tok || (pop && (cwe_pkg::CNT_W'(rd_q) + 1'b1 == cnt_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load_i) begin
        cnt_q <= batch_i.cnt;
        rd_q  <= '0;
      end else if (pop) begin
        rd_q  <= rd_q + 1'b1;
      end
      if (pop) begin
        out_valid_q <= 1'b1;
      end else if (token_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      slots_q <= batch_i.tokens;
    end
    if (pop) begin
      out_tok_q <= slots_q[rd_q];
    end
  end

  assign token_o.valid       = out_valid_q;
  assign token_o.token_kind  = out_tok_q.kind;
  assign token_o.token_value = out_tok_q.value;
  assign token_o.array_done  = out_tok_q.done;

endmodule

### hw/rtl/cid_width_array_encoder.sv
// Compacted glyph-width array encoder. Takes (glyph id, width) requests in
// ascending id order, widths in unsigned Q16.8, and streams width-array tokens:
// same-width ranges (first id, last id, width) and open lists (start id, widths,
// close). Widths within one unit of the width that opened a stretch count as
// equal; emitted widths are rounded half up and saturate at 65535. An id gap
// flushes the pending run, and a request marked final flushes everything and
// flags its last token with array_done. Rate: a request is taken every cycle
// as long as each causes at most one token and the token sink is ready; one
// causing more (up to six) holds the next in the input register until its last
// token moves to the output register, as the token channel moves one token per
// cycle. Requests pass the input register, their tokens the output register.
// Depends on cwe_pkg, cwe_item_if, cwe_token_if, cwe_encode, cwe_token_queue.
module cid_width_array_encoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  cwe_item_if.sink    item_i,
  cwe_token_if.source token_o
);

  // Input register: holds one request until the token queue takes its batch.
  logic                         item_valid_q;
  cwe_pkg::item_t               item_q;
  logic                         take, accept, q_free;
  cwe_pkg::batch_t              enc_batch;
  cwe_pkg::enc_state_t          enc_state;

  assign take         = item_valid_q && q_free;
  assign item_i.ready = !item_valid_q || take;
  assign accept       = item_i.valid && item_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q <= 1'b0;
    end else if (accept) begin
      item_valid_q <= 1'b1;
    end else if (take) begin
      item_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.glyph_id    <= item_i.glyph_id;
      item_q.glyph_width <= item_i.glyph_width;
      item_q.final_entry <= item_i.final_entry;
    end
  end

  // Encoder core: advance the run state and build the token batch on take.
  cwe_encode u_encode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .item_i  (item_q),
    .take_i  (take),
    .batch_o (enc_batch),
    .state_o (enc_state)
  );

  // Token queue and output register: drain the batch one token per cycle while the sink is ready.
  cwe_token_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (take),
    .batch_i (enc_batch),
    .free_o  (q_free),
    .token_o (token_o)
  );

  // Done flags of the batch, gathered for checking.
  logic [cwe_pkg::MAX_TOKENS-1:0] done_vec;
  always_comb begin
    for (int i = 0; i < cwe_pkg::MAX_TOKENS; i++) begin
      done_vec[i] = enc_batch.tokens[i].done;
    end
  end

`ifndef SYNTHESIS
  // A final request carries exactly one done flag, any other none.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |-> ($countones(done_vec) == (item_q.final_entry ? 1 : 0)))
    else $error("done flag count does not match final request");

  // A final request always flushes at least two tokens, e.g. a list width and close.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && item_q.final_entry |-> (enc_batch.cnt >= cwe_pkg::CNT_W'(2)))
    else $error("final request flushed too few tokens");

  // After a final request no run is pending and no list is open.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && item_q.final_entry |=> (!enc_state.pending && !enc_state.list_open))
    else $error("run state not cleared after final request");
`endif

endmodule
